// ----- rtl/signed_hex_decimal_atoi_assert.svh -----
// Assertion macros shared by the parser modules.
`ifndef SIGNED_HEX_DECIMAL_ATOI_ASSERT_SVH
`define SIGNED_HEX_DECIMAL_ATOI_ASSERT_SVH
`ifndef SYNTH
`define SHDA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SHDA_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define SHDA_ASSERT(lbl, clk, rstn, prop, msg)
`define SHDA_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif
`endif

// ----- rtl/shda_pkg.sv -----
package shda_pkg;

  typedef enum logic [5:0] {
    PH_START  = 6'b000001,
    PH_SIGNED = 6'b000010,
    PH_ZERO   = 6'b000100,
    PH_DEC    = 6'b001000,
    PH_HEX    = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_t;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_DEC  = 2'd1,
    OP_HEX  = 2'd2
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [3:0] digit;
    logic       last;
    logic       neg;
  } op_t;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [3:0] HEX_LETTER_OFS = 4'd9;

endpackage

// ----- rtl/shda_front.sv -----
`include "signed_hex_decimal_atoi_assert.svh"
module shda_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc_en,
  input  logic [7:0]       char_code,
  input  logic             is_last,
  output shda_pkg::op_t    op
);

  shda_pkg::phase_t phase_r, phase_nxt, phase_upd;
  logic neg_r, neg_nxt, neg_upd;
  logic is_dec, is_hex_lc, is_hex_uc, is_zero, is_x;
  logic [3:0] dec_val, hex_val;
  shda_pkg::op_kind_t kind;
  logic [3:0] digit;

  always_comb begin
    is_dec    = (char_code >= shda_pkg::CH_ZERO) && (char_code <= shda_pkg::CH_NINE);
    is_hex_lc = (char_code >= shda_pkg::CH_LA) && (char_code <= shda_pkg::CH_LF);
    is_hex_uc = (char_code >= shda_pkg::CH_UA) && (char_code <= shda_pkg::CH_UF);
    is_zero   = (char_code == shda_pkg::CH_ZERO);
    is_x      = (char_code == shda_pkg::CH_LX) || (char_code == shda_pkg::CH_UX);
    dec_val   = char_code[3:0];
    hex_val   = is_dec ? char_code[3:0] : char_code[3:0] + shda_pkg::HEX_LETTER_OFS;
  end

  always_comb begin
    phase_upd = phase_r;
    neg_upd   = neg_r;
    kind      = shda_pkg::OP_NONE;
    digit     = dec_val;
    unique case (phase_r)
      shda_pkg::PH_START, shda_pkg::PH_SIGNED: begin
        if (phase_r == shda_pkg::PH_START && char_code == shda_pkg::CH_MINUS) begin
          neg_upd   = 1'b1;
          phase_upd = shda_pkg::PH_SIGNED;
        end else if (is_zero) begin
          phase_upd = shda_pkg::PH_ZERO;
        end else if (is_dec) begin
          kind      = shda_pkg::OP_DEC;
          phase_upd = shda_pkg::PH_DEC;
        end else begin
          phase_upd = shda_pkg::PH_DONE;
        end
      end
      shda_pkg::PH_ZERO: begin
        if (is_x) begin
          phase_upd = shda_pkg::PH_HEX;
        end else if (is_dec) begin
          kind      = shda_pkg::OP_DEC;
          phase_upd = shda_pkg::PH_DEC;
        end else begin
          phase_upd = shda_pkg::PH_DONE;
        end
      end
      shda_pkg::PH_DEC: begin
        if (is_dec) begin
          kind = shda_pkg::OP_DEC;
        end else begin
          phase_upd = shda_pkg::PH_DONE;
        end
      end
      shda_pkg::PH_HEX: begin
        digit = hex_val;
        if (is_dec || is_hex_lc || is_hex_uc) begin
          kind = shda_pkg::OP_HEX;
        end else begin
          phase_upd = shda_pkg::PH_DONE;
        end
      end
      default: begin
        phase_upd = shda_pkg::PH_DONE;
      end
    endcase
  end

  always_comb begin
    op.kind  = kind;
    op.digit = digit;
    op.last  = is_last;
    op.neg   = neg_upd;
    if (is_last) begin
      phase_nxt = shda_pkg::PH_START;
      neg_nxt   = 1'b0;
    end else begin
      phase_nxt = phase_upd;
      neg_nxt   = neg_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= shda_pkg::PH_START;
      neg_r   <= 1'b0;
    end else if (acc_en) begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
    end
  end

  `SHDA_ASSERT_NEXT(a_front_restart, clk, rst_n, acc_en && is_last, phase_r == shda_pkg::PH_START && !neg_r, "phase not restarted after last item")

endmodule

// ----- rtl/shda_opq.sv -----
`include "signed_hex_decimal_atoi_assert.svh"
module shda_opq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  shda_pkg::op_t push_op,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output shda_pkg::op_t head
);

  shda_pkg::op_t mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign valid   = (cnt_r != 2'd0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  `SHDA_ASSERT(a_opq_bound, clk, rst_n, cnt_r != 2'd3, "operation queue count out of range")
  `SHDA_ASSERT_NEXT(a_opq_grow, clk, rst_n, do_push && !do_pop, cnt_r == $past(cnt_r) + 2'd1, "operation queue count did not grow")

endmodule

// ----- rtl/shda_back.sv -----
`include "signed_hex_decimal_atoi_assert.svh"
module shda_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               op_valid,
  input  shda_pkg::op_t      op,
  output logic               op_pop,
  output logic               res_empty,
  input  logic               res_pop,
  output logic signed [31:0] res_value
);

  logic [31:0] acc_r, acc_nxt, acc_mac, result;
  logic [31:0] res_mem_r [2];
  logic        res_wr_ptr_r, res_rd_ptr_r;
  logic [1:0]  res_cnt_r, res_cnt_nxt;
  logic        res_full, res_push, res_take;

  assign res_full  = (res_cnt_r == 2'd2);
  assign res_empty = (res_cnt_r == 2'd0);
  assign res_value = res_mem_r[res_rd_ptr_r];
  assign op_pop    = op_valid && (!op.last || !res_full);
  assign res_push  = op_pop && op.last;
  assign res_take  = res_pop && !res_empty;

  always_comb begin
    case (op.kind)
      shda_pkg::OP_DEC: acc_mac = {acc_r[28:0], 3'b000} + {acc_r[30:0], 1'b0} + {28'd0, op.digit};
      shda_pkg::OP_HEX: acc_mac = {acc_r[27:0], op.digit};
      default:          acc_mac = acc_r;
    endcase
    result  = op.neg ? (32'd0 - acc_mac) : acc_mac;
    acc_nxt = op.last ? 32'd0 : acc_mac;
  end

  always_comb begin
    res_cnt_nxt = res_cnt_r;
    if (res_push && !res_take) begin
      res_cnt_nxt = res_cnt_r + 2'd1;
    end else if (res_take && !res_push) begin
      res_cnt_nxt = res_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_mem_r[res_wr_ptr_r] <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r        <= 32'd0;
      res_wr_ptr_r <= 1'b0;
      res_rd_ptr_r <= 1'b0;
      res_cnt_r    <= 2'd0;
    end else begin
      if (op_pop) begin
        acc_r <= acc_nxt;
      end
      if (res_push) begin
        res_wr_ptr_r <= ~res_wr_ptr_r;
      end
      if (res_take) begin
        res_rd_ptr_r <= ~res_rd_ptr_r;
      end
      res_cnt_r <= res_cnt_nxt;
    end
  end

  `SHDA_ASSERT_NEXT(a_back_clear, clk, rst_n, op_pop && op.last, acc_r == 32'd0, "accumulator not cleared after last item")
  `SHDA_ASSERT(a_back_bound, clk, rst_n, res_cnt_r != 2'd3, "result queue count out of range")

endmodule

// ----- rtl/signed_hex_decimal_atoi.sv -----
// A result reaches out_value after the last character's operation passes the operation queue, then the result queue.
// Throughput: one character per cycle while in_full is low, limited by the single accumulator update per cycle.
// A two-entry operation queue and a two-entry result queue decouple the stages.
// Reset: synchronous, active low; clears phase, sign, accumulator and both queues.
module signed_hex_decimal_atoi (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [7:0]         in_char_code,
  input  logic               in_is_last,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_value
);

  shda_pkg::op_t front_op, head_op;
  logic          in_acc, q_valid, q_pop;

  assign in_acc = in_push && !in_full;

  shda_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc_en    (in_acc),
    .char_code (in_char_code),
    .is_last   (in_is_last),
    .op        (front_op)
  );

  shda_opq u_opq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .push_op (front_op),
    .full    (in_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .head    (head_op)
  );

  shda_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (q_valid),
    .op        (head_op),
    .op_pop    (q_pop),
    .res_empty (out_empty),
    .res_pop   (out_pop),
    .res_value (out_value)
  );

endmodule
